/* hdl/sfmf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sfmf_pkg;

    localparam int MAX_NEEDLE    = 32;
    localparam int POSITION_BITS = 32;
    localparam int REG_BYTES     = 32;
    localparam int LEN_CAP       = (MAX_NEEDLE < REG_BYTES) ? MAX_NEEDLE : REG_BYTES;
    localparam int LEN_W         = $clog2(LEN_CAP + 1);
    localparam int SHIFT_W       = LEN_W + 3;

    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int LENGTH_W      = 6;
    localparam int RESULT_POS_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_0_7    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_8_15   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_16_23  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_24_31  = 3'd4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic                    found;
        logic [RESULT_POS_W-1:0] match_position;
    } out_word_t;

endpackage

`default_nettype wire

/* hdl/substring_first_match_finder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      in_valid / in_ready        in_data  (text_byte, end_of_text)
// out       output     out_valid / out_ready      out_data (found, match_position)
// cfg       input      cfg_we                     cfg_index, cfg_data
//
// One byte is accepted per cycle unless the input stalls. A byte sits in the input
// register and is compared in parallel against the whole window; its result, if any,
// is registered in the result register. The needle is realigned into a register from
// the configuration registers after a write. Reset clears the configuration, the
// haystack count and the answered flag, not the window. The input stalls only while a
// result waits at the output and the byte held in the input register has to move on.

module substring_first_match_finder (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_ready,
    input  wire sfmf_pkg::in_word_t                in_data,
    output logic                                   out_valid,
    input  wire                                    out_ready,
    output sfmf_pkg::out_word_t                    out_data,
    input  wire                                    cfg_we,
    input  wire [sfmf_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire [sfmf_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int CAP     = sfmf_pkg::LEN_CAP;
    localparam int LW      = sfmf_pkg::LEN_W;
    localparam int PW      = sfmf_pkg::POSITION_BITS;
    localparam int SW      = sfmf_pkg::SHIFT_W;
    localparam logic [PW-1:0] COUNT_MAX = {PW{1'b1}};

    // Configuration registers.
    logic [sfmf_pkg::LENGTH_W-1:0]   needle_length_reg;
    logic [sfmf_pkg::CFG_DATA_W-1:0] needle_word_reg [4];

    // Needle realigned to the window, newest byte first.
    logic [CAP*8-1:0] aligned_reg, aligned_next;
    logic [CAP-1:0]   mask_reg, mask_next;
    logic [LW-1:0]    len_reg, len_next;

    // Input register.
    logic                 s1_valid_reg;
    sfmf_pkg::in_word_t   s1_word_reg;

    // Haystack state.
    logic [7:0]      window_reg [CAP];
    logic [7:0]      window_next [CAP];
    logic [PW-1:0]   count_reg, count_next;
    logic            answered_reg, answered_next;

    // Result register.
    logic                 out_valid_reg;
    sfmf_pkg::out_word_t  out_word_reg, out_word_next;

    logic            advance;
    logic            emit;
    logic            is_match;
    logic [CAP-1:0]  byte_ok;
    logic [PW-1:0]   position;

    // Needle alignment, computed from the configuration registers.
    always_comb
    begin
        logic [4*sfmf_pkg::CFG_DATA_W-1:0] all_bytes;
        logic [CAP*8-1:0]                  rev_needle;
        logic [LW-1:0]                     shift_bytes;
        logic [SW-1:0]                     shift_bits;
        all_bytes = {needle_word_reg[3], needle_word_reg[2],
                     needle_word_reg[1], needle_word_reg[0]};
        if (needle_length_reg > sfmf_pkg::LENGTH_W'(CAP))
        begin
            len_next = LW'(CAP);
        end
        else
        begin
            len_next = LW'(needle_length_reg);
        end
        for (int i = 0; i < CAP; i++)
        begin
            rev_needle[8*i +: 8] = all_bytes[8*(CAP-1-i) +: 8];
            mask_next[i]         = (LW'(i) < len_next);
        end
        shift_bytes  = LW'(CAP) - len_next;
        shift_bits   = {shift_bytes, 3'b000};
        aligned_next = rev_needle >> shift_bits;
    end

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // Window compare and decision for the byte in the input register.
    always_comb
    begin
        window_next[0] = s1_word_reg.text_byte;
        for (int i = 1; i < CAP; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
        for (int i = 0; i < CAP; i++)
        begin
            byte_ok[i] = !mask_reg[i] || (window_next[i] == aligned_reg[8*i +: 8]);
        end
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + PW'(1);
        position   = count_next - PW'(len_reg);
        is_match   = (count_next >= PW'(len_reg)) && (&byte_ok);

        emit          = 1'b0;
        out_word_next = '0;
        if (!answered_reg)
        begin
            priority if (len_reg == '0)
            begin
                emit = 1'b1;
                out_word_next.found = 1'b1;
            end
            else if (is_match)
            begin
                emit = 1'b1;
                out_word_next.found          = 1'b1;
                out_word_next.match_position = sfmf_pkg::RESULT_POS_W'(position);
            end
            else if (s1_word_reg.end_of_text)
            begin
                emit = 1'b1;
            end
            else
            begin
                emit = 1'b0;
            end
        end
        answered_next = s1_word_reg.end_of_text ? 1'b0 : (answered_reg || emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_length_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                needle_word_reg[i] <= '0;
            end
            aligned_reg   <= '0;
            mask_reg      <= '0;
            len_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            count_reg     <= '0;
            answered_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sfmf_pkg::REG_NEEDLE_LENGTH:
                        needle_length_reg <= cfg_data[sfmf_pkg::LENGTH_W-1:0];
                    sfmf_pkg::REG_NEEDLE_0_7:   needle_word_reg[0] <= cfg_data;
                    sfmf_pkg::REG_NEEDLE_8_15:  needle_word_reg[1] <= cfg_data;
                    sfmf_pkg::REG_NEEDLE_16_23: needle_word_reg[2] <= cfg_data;
                    sfmf_pkg::REG_NEEDLE_24_31: needle_word_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
            aligned_reg <= aligned_next;
            mask_reg    <= mask_next;
            len_reg     <= len_next;

            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end

            if (advance)
            begin
                count_reg     <= s1_word_reg.end_of_text ? '0 : count_next;
                answered_reg  <= answered_next;
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_word_reg <= in_data;
        end
        if (advance)
        begin
            for (int i = 0; i < CAP; i++)
            begin
                window_reg[i] <= window_next[i];
            end
            if (emit)
            begin
                out_word_reg <= out_word_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // A result for an unfinished haystack blocks further results for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit && !s1_word_reg.end_of_text) |=> answered_reg)
        else $error("answered flag not set after a result");

    // The last byte of a haystack returns the haystack state to its start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_word_reg.end_of_text) |=> (count_reg == '0) && !answered_reg)
        else $error("haystack state not cleared after the last byte");

    // Input stalls only when a result is held at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && !out_ready && s1_valid_reg))
        else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire

/* tb/sv/first_match_checker.sv */
`timescale 1ns / 1ps

module first_match_checker (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    input  wire                              in_ready,
    input  sfmf_pkg::in_word_t               in_data,
    input  wire                              out_valid,
    input  wire                              out_ready,
    input  sfmf_pkg::out_word_t              out_data,
    input  wire                              cfg_we,
    input  wire [sfmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire [sfmf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               mismatches,
    output int                               pending
);

    logic [sfmf_pkg::LENGTH_W-1:0]      needle_len_cfg;
    logic [sfmf_pkg::CFG_DATA_W-1:0]    needle_cfg [4];
    logic [7:0]                         history [sfmf_pkg::LEN_CAP];
    logic [sfmf_pkg::POSITION_BITS-1:0] text_count;
    logic                               answered;
    sfmf_pkg::out_word_t                expected_results [$];
    int                                 mismatch_count = 0;
    int                                 expected_count = 0;

    assign mismatches = mismatch_count;
    assign pending    = expected_count;

    task automatic report_mismatch(input string what);
        $display("%0t first_match_checker: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic clear_text();
        for (int i = 0; i < sfmf_pkg::LEN_CAP; i++)
        begin
            history[i] = 8'h00;
        end
        text_count = '0;
        answered   = 1'b0;
    endtask

    function automatic logic [7:0] needle_byte(input int j);
        return needle_cfg[j / 8][8 * (j % 8) +: 8];
    endfunction

    function automatic logic window_matches(input int len);
        for (int j = 0; j < len; j++)
        begin
            if (needle_byte(j) != history[len - 1 - j])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Each word shifts into the window; at most one result per text, the first match
    // or a not-found on the last word.
    task automatic predict_first_match(input sfmf_pkg::in_word_t w);
        int                  len;
        sfmf_pkg::out_word_t r;
        len = (needle_len_cfg > sfmf_pkg::LEN_CAP) ? sfmf_pkg::LEN_CAP
                                                   : int'(needle_len_cfg);
        for (int i = sfmf_pkg::LEN_CAP - 1; i > 0; i--)
        begin
            history[i] = history[i - 1];
        end
        history[0] = w.text_byte;
        if (text_count != '1)
            text_count++;
        if (!answered)
        begin
            r.found          = 1'b1;
            r.match_position = '0;
            if (len == 0)
            begin
                answered = 1'b1;
            end
            else if (text_count >= len && window_matches(len))
            begin
                r.match_position = sfmf_pkg::RESULT_POS_W'(text_count - len);
                answered         = 1'b1;
            end
            else if (w.end_of_text)
            begin
                r.found  = 1'b0;
                answered = 1'b1;
            end
            if (answered)
                expected_results.push_back(r);
        end
        if (w.end_of_text)
            clear_text();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sfmf_pkg::out_word_t want;
        if (!rst_n)
        begin
            needle_len_cfg = '0;
            for (int k = 0; k < 4; k++)
            begin
                needle_cfg[k] = '0;
            end
            clear_text();
            expected_results.delete();
            expected_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_first_match(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                              out_data.found, out_data.match_position));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.found !== want.found)
                        report_mismatch($sformatf("found is %0b, expected %0b",
                                                  out_data.found, want.found));
                    if (out_data.match_position !== want.match_position)
                        report_mismatch($sformatf("match_position is %0d, expected %0d",
                                                  out_data.match_position,
                                                  want.match_position));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    sfmf_pkg::REG_NEEDLE_LENGTH:
                        needle_len_cfg = cfg_data[sfmf_pkg::LENGTH_W-1:0];
                    sfmf_pkg::REG_NEEDLE_0_7:   needle_cfg[0] = cfg_data;
                    sfmf_pkg::REG_NEEDLE_8_15:  needle_cfg[1] = cfg_data;
                    sfmf_pkg::REG_NEEDLE_16_23: needle_cfg[2] = cfg_data;
                    sfmf_pkg::REG_NEEDLE_24_31: needle_cfg[3] = cfg_data;
                    default:                    ;
                endcase
            end
            expected_count <= expected_results.size();
        end
    end

endmodule

/* tb/sv/substring_first_match_finder_tb.sv */
`timescale 1ns / 1ps

module substring_first_match_finder_tb;

    localparam int CLOCK_LIMIT = 400000;
    localparam int SETTLE      = 4;
    localparam int ROUND_WORDS = 28;
    localparam int IN_W        = $bits(sfmf_pkg::in_word_t);

    logic                              clk        = 1'b0;
    logic                              rst_n      = 1'b0;
    logic                              in_valid   = 1'b0;
    logic                              in_ready;
    sfmf_pkg::in_word_t                in_data    = '0;
    logic                              out_valid;
    logic                              out_ready  = 1'b0;
    sfmf_pkg::out_word_t               out_data;
    logic                              cfg_we     = 1'b0;
    logic [sfmf_pkg::CFG_INDEX_W-1:0]  cfg_index  = '0;
    logic [sfmf_pkg::CFG_DATA_W-1:0]   cfg_data   = '0;

    int                      mismatches;
    int                      pending;
    int                      send_idle  = 0;
    int                      recv_stall = 0;
    int                      cycle_count = 0;
    int                      words_sent = 0;
    logic [7:0]              needle_pat [sfmf_pkg::LEN_CAP];
    int                      needle_used = 0;
    logic [7:0]              text [$];

    substring_first_match_finder dut (.*);

    first_match_checker match_check (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CLOCK_LIMIT)
        begin
            $display("substring_first_match_finder_tb: FAIL");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic eot);
        sfmf_pkg::in_word_t  w;
        logic [IN_W-1:0]     noise;
        w.text_byte   = b;
        w.end_of_text = eot;
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            noise = IN_W'($urandom);
            in_valid <= 1'b0;
            in_data  <= noise;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    task automatic drain(input int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(input logic [sfmf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [sfmf_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // Writes to the unused indexes are mixed in now and then; the block must ignore them.
    task automatic set_needle(input logic [sfmf_pkg::LENGTH_W-1:0] len,
                              input logic [4*sfmf_pkg::CFG_DATA_W-1:0] pat);
        drain(SETTLE);
        if ($urandom_range(2) == 0)
            write_reg(sfmf_pkg::CFG_INDEX_W'($urandom_range(2**sfmf_pkg::CFG_INDEX_W - 1,
                                                            sfmf_pkg::REG_NEEDLE_24_31 + 1)),
                      {$urandom, $urandom});
        write_reg(sfmf_pkg::REG_NEEDLE_LENGTH, sfmf_pkg::CFG_DATA_W'(len));
        for (int k = 0; k < 4; k++)
        begin
            write_reg(sfmf_pkg::CFG_INDEX_W'(sfmf_pkg::REG_NEEDLE_0_7 + k),
                      pat[sfmf_pkg::CFG_DATA_W*k +: sfmf_pkg::CFG_DATA_W]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        for (int j = 0; j < sfmf_pkg::LEN_CAP; j++)
        begin
            needle_pat[j] = pat[8*j +: 8];
        end
        needle_used = (len > sfmf_pkg::LEN_CAP) ? sfmf_pkg::LEN_CAP : int'(len);
    endtask

    task automatic send_text(input bit pause_inside);
        for (int i = 0; i < text.size(); i++)
        begin
            send_word(text[i], i == text.size() - 1);
            if (pause_inside && i == 0)
                drain(0);
        end
    endtask

    function automatic logic [7:0] filler();
        if (needle_used > 0 && $urandom_range(1) == 1)
            return needle_pat[$urandom_range(needle_used - 1)];
        return 8'($urandom);
    endfunction

    task automatic random_needle();
        logic [sfmf_pkg::LENGTH_W-1:0]     len;
        logic [4*sfmf_pkg::CFG_DATA_W-1:0] pat;
        logic [7:0]                        a;
        logic [7:0]                        b;
        case ($urandom_range(9))
            0:          len = '0;
            1:          len = sfmf_pkg::LENGTH_W'(1);
            2:          len = sfmf_pkg::LENGTH_W'(sfmf_pkg::LEN_CAP);
            3:          len = '1;
            4, 5, 6, 7: len = sfmf_pkg::LENGTH_W'($urandom_range(6, 2));
            default:    len = sfmf_pkg::LENGTH_W'($urandom);
        endcase
        case ($urandom_range(3))
            0: pat = '0;
            1: pat = '1;
            2:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    pat[32*i +: 32] = $urandom;
                end
            end
            default:
            begin
                a = 8'($urandom);
                b = 8'($urandom);
                for (int i = 0; i < 32; i++)
                begin
                    pat[8*i +: 8] = ($urandom_range(1) == 1) ? a : b;
                end
            end
        endcase
        set_needle(len, pat);
    endtask

    // Mostly texts that hold the needle, some with one bit broken, some noise and
    // some that stop inside the needle.
    task automatic make_text();
        int kind;
        int pre;
        int n;
        int idx;
        text.delete();
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            pre = $urandom_range(8);
            repeat (pre) text.push_back(filler());
            for (int j = 0; j < needle_used; j++)
            begin
                text.push_back(needle_pat[j]);
            end
            if (kind >= 55 && needle_used > 0)
            begin
                idx       = pre + $urandom_range(needle_used - 1);
                text[idx] = text[idx] ^ (8'd1 << $urandom_range(7));
            end
            repeat ($urandom_range(4)) text.push_back(filler());
            if (text.size() == 0)
                text.push_back(filler());
        end
        else if (kind < 88)
        begin
            repeat ($urandom_range(12, 1)) text.push_back(filler());
        end
        else
        begin
            n = $urandom_range(needle_used > 1 ? needle_used - 1 : 1, 1);
            for (int j = 0; j < n; j++)
            begin
                text.push_back(j < needle_used ? needle_pat[j] : filler());
            end
        end
    endtask

    initial
    begin
        int send_pct [4];
        int recv_pct [4];
        int round_start;
        bit first;
        send_pct = '{0, 74, 0, 20};
        recv_pct = '{0, 0, 74, 20};
        for (int j = 0; j < sfmf_pkg::LEN_CAP; j++)
        begin
            needle_pat[j] = 8'h00;
        end
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // An empty needle matches at the first word of each text.
        text = '{8'hFF, 8'h00};
        send_text(1'b0);

        set_needle(sfmf_pkg::LENGTH_W'(1), 256'hFF);
        text = '{8'h00};
        send_text(1'b0);
        text = '{8'h12, 8'hFF, 8'hFF};
        send_text(1'b0);

        // The window must not match a zero needle before enough words of the text have come.
        set_needle(sfmf_pkg::LENGTH_W'(3), '0);
        text = '{8'h00, 8'h00};
        send_text(1'b0);
        text = '{8'h00, 8'h00, 8'h00, 8'h01};
        send_text(1'b0);

        // A length above the register capacity is clamped, and the text is too short.
        set_needle('1, '1);
        text = '{8'hFF, 8'hFF, 8'hFF};
        send_text(1'b0);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle  = send_pct[phase];
            recv_stall = recv_pct[phase];
            for (int round = 0; round < 4; round++)
            begin
                random_needle();
                round_start = words_sent;
                first       = 1'b1;
                while (words_sent - round_start < ROUND_WORDS)
                begin
                    make_text();
                    send_text(first);
                    first = 1'b0;
                end
            end
        end

        drain(2 * SETTLE);
        if (mismatches == 0)
            $display("substring_first_match_finder_tb: PASS");
        else
            $display("substring_first_match_finder_tb: FAIL");
        $finish;
    end

endmodule
